FILE: hdl/bccp_pkg.sv
package bccp_pkg;

    // Defaults for the ramp and integral bounds
    localparam int SPEED_TARGET_MAX_DEF = 10;
    localparam int TURN_TARGET_MAX_DEF  = 100;
    localparam int INTEGRAL_LIMIT_DEF   = 20000;

    // Turn ramp step per tick
    localparam int TURN_STEP = 30;

    // Configuration port
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;

    // Datapath widths
    localparam int MUL_A_W    = 32;
    localparam int MUL_B_W    = 25;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int ACC_W      = PROD_W + 1;
    localparam int ERR_W      = 18;
    localparam int FE_W       = 18;
    localparam int MIX_W      = 22;
    localparam int VEL_W      = 16;
    localparam int TRUNC_LO   = 16;
    localparam int TRUNC_HI   = 24;
    localparam int UP_W       = ACC_W - TRUNC_HI;
    localparam int TURN_SUM_W = 33;
    localparam int DRV_SUM_W  = 35;
    localparam int DRV_W      = 16;
    localparam int LIM_W      = 15;

    // x/10 as (x * RECIP10) >> RECIP_SHIFT, exact for 0 <= x < 2^22
    localparam int RECIP10     = 838861;
    localparam int RECIP_SHIFT = 23;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_UPRIGHT_KP     = 3'd0,
        REG_UPRIGHT_KD     = 3'd1,
        REG_SPEED_KP       = 3'd2,
        REG_SPEED_KI       = 3'd3,
        REG_STEER_KP       = 3'd4,
        REG_STEER_KD       = 3'd5,
        REG_BALANCE_OFFSET = 3'd6,
        REG_DRIVE_LIMIT    = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic signed [31:0]    upright_kp;
        logic signed [31:0]    upright_kd;
        logic signed [31:0]    speed_kp;
        logic signed [31:0]    speed_ki;
        logic signed [31:0]    steer_kp;
        logic signed [31:0]    steer_kd;
        logic signed [15:0]    balance_offset;
        logic [LIM_W-1:0]      drive_limit;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        upright_kp:     -32'sd11796480,
        upright_kd:     -32'sd58982,
        speed_kp:       -32'sd52429,
        speed_ki:       -32'sd262,
        steer_kp:       32'sd655360,
        steer_kd:       32'sd39322,
        balance_offset: 16'sd0,
        drive_limit:    15'd7000
    };

    // Input and result items
    typedef struct packed {
        logic signed [15:0] enc_left;
        logic signed [15:0] enc_right_raw;
        logic signed [15:0] roll_angle;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_z;
        logic               fwd_btn;
        logic               back_btn;
        logic               left_btn;
        logic               right_btn;
        logic               obstacle_near;
        logic               clear_integral;
    } t_in_item;

    typedef struct packed {
        logic signed [DRV_W-1:0] drive_left;
        logic signed [DRV_W-1:0] drive_right;
    } t_out_item;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RAMP,
        ST_DIV,
        ST_FILT,
        ST_INTEG,
        ST_VKI,
        ST_VACC,
        ST_VEL,
        ST_UKP,
        ST_UKD,
        ST_UACC,
        ST_UPR,
        ST_TACC,
        ST_TURN,
        ST_OUT
    } t_state;

    // Shared multiplier operand select
    typedef enum logic [2:0] {
        MS_RECIP,
        MS_SKP,
        MS_SKI,
        MS_UKP,
        MS_UKD,
        MS_TKP,
        MS_TKD
    } t_mul_sel;

    // Accumulator operation
    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_ADD_SH8
    } t_acc_op;

    typedef struct packed {
        logic     in_load;
        logic     ramp;
        logic     div_start;
        logic     div_fin;
        logic     int_upd;
        logic     vel_upd;
        logic     up_upd;
        logic     turn_upd;
        logic     trunc_hi;
        logic     out_load;
        t_mul_sel mul_sel;
        t_acc_op  acc_op;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

FILE: hdl/bccp_ctrl.sv
module bccp_ctrl
    import bccp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_in_valid) n_state = ST_RAMP;
            ST_RAMP:  n_state = ST_DIV;
            ST_DIV:   n_state = ST_FILT;
            ST_FILT:  n_state = ST_INTEG;
            ST_INTEG: n_state = ST_VKI;
            ST_VKI:   n_state = ST_VACC;
            ST_VACC:  n_state = ST_VEL;
            ST_VEL:   n_state = ST_UKP;
            ST_UKP:   n_state = ST_UKD;
            ST_UKD:   n_state = ST_UACC;
            ST_UACC:  n_state = ST_UPR;
            ST_UPR:   n_state = ST_TACC;
            ST_TACC:  n_state = ST_TURN;
            ST_TURN:  n_state = ST_OUT;
            ST_OUT:   if (i_status.out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Commands per state
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.mul_sel = MS_RECIP;
        o_cmd.acc_op  = ACC_HOLD;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.in_load = i_in_valid;
            end
            ST_RAMP: o_cmd.ramp = 1'b1;
            ST_DIV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.mul_sel   = MS_RECIP;
            end
            ST_FILT: o_cmd.div_fin = 1'b1;
            ST_INTEG: begin
                o_cmd.int_upd = 1'b1;
                o_cmd.mul_sel = MS_SKP;
            end
            ST_VKI: begin
                o_cmd.mul_sel = MS_SKI;
                o_cmd.acc_op  = ACC_LOAD;
            end
            ST_VACC: o_cmd.acc_op = ACC_ADD;
            ST_VEL:  o_cmd.vel_upd = 1'b1;
            ST_UKP:  o_cmd.mul_sel = MS_UKP;
            ST_UKD: begin
                o_cmd.mul_sel = MS_UKD;
                o_cmd.acc_op  = ACC_LOAD;
            end
            ST_UACC: begin
                o_cmd.acc_op  = ACC_ADD_SH8;
                o_cmd.mul_sel = MS_TKP;
            end
            ST_UPR: begin
                o_cmd.up_upd   = 1'b1;
                o_cmd.trunc_hi = 1'b1;
                o_cmd.acc_op   = ACC_LOAD;
                o_cmd.mul_sel  = MS_TKD;
            end
            ST_TACC: o_cmd.acc_op = ACC_ADD;
            ST_TURN: o_cmd.turn_upd = 1'b1;
            ST_OUT:  o_cmd.out_load = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

FILE: hdl/bccp_dp.sv
module bccp_dp
    import bccp_pkg::*;
#(
    parameter int SPEED_TARGET_MAX = SPEED_TARGET_MAX_DEF,
    parameter int TURN_TARGET_MAX  = TURN_TARGET_MAX_DEF,
    parameter int INTEGRAL_LIMIT   = INTEGRAL_LIMIT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  t_in_item   i_in_data,
    input  t_dp_cmd    i_cmd,
    input  logic       i_out_ready,
    output t_dp_status o_status,
    output logic       o_out_valid,
    output t_out_item  o_out_data
);

    localparam int SPD_W     = $clog2(SPEED_TARGET_MAX + 1) + 1;
    localparam int TURN_W    = $clog2(TURN_TARGET_MAX + 1) + 1;
    localparam int INT_W     = $clog2(INTEGRAL_LIMIT + 1) + 1;
    localparam int RMP_S_W   = SPD_W + 2;
    localparam int RMP_T_W   = ((TURN_W > 6) ? TURN_W : 6) + 2;
    localparam int INT_SUM_W = ((INT_W > FE_W) ? INT_W : FE_W) + 1;
    localparam int VRAW_W    = ACC_W - TRUNC_LO;

    localparam logic signed [RMP_S_W-1:0]   SPD_HI  = RMP_S_W'(SPEED_TARGET_MAX);
    localparam logic signed [RMP_S_W-1:0]   SPD_LO  = -RMP_S_W'(SPEED_TARGET_MAX);
    localparam logic signed [RMP_T_W-1:0]   TURN_HI = RMP_T_W'(TURN_TARGET_MAX);
    localparam logic signed [RMP_T_W-1:0]   TURN_LO = -RMP_T_W'(TURN_TARGET_MAX);
    localparam logic signed [RMP_T_W-1:0]   TSTEP   = RMP_T_W'(TURN_STEP);
    localparam logic signed [INT_SUM_W-1:0] INT_HI  = INT_SUM_W'(INTEGRAL_LIMIT);
    localparam logic signed [INT_SUM_W-1:0] INT_LO  = -INT_SUM_W'(INTEGRAL_LIMIT);
    localparam logic signed [VRAW_W-1:0]    VEL_HI  = VRAW_W'(32767);
    localparam logic signed [VRAW_W-1:0]    VEL_LO  = -VRAW_W'(32768);
    localparam logic signed [ACC_W-1:0]     BIAS_LO = ACC_W'((64'sd1 <<< TRUNC_LO) - 1);
    localparam logic signed [ACC_W-1:0]     BIAS_HI = ACC_W'((64'sd1 <<< TRUNC_HI) - 1);

    // Registers
    t_in_item                 r_in;
    logic signed [SPD_W-1:0]  r_speed_target, n_speed_target;
    logic signed [TURN_W-1:0] r_turn_target,  n_turn_target;
    logic signed [ERR_W-1:0]  r_err,          n_err;
    logic signed [FE_W-1:0]   r_fe,           n_fe;
    logic signed [INT_W-1:0]  r_si,           n_si;
    logic                     r_neg;
    logic signed [PROD_W-1:0] r_prod,         n_prod;
    logic signed [ACC_W-1:0]  r_acc,          n_acc;
    logic signed [VEL_W-1:0]  r_vel,          n_vel;
    logic signed [UP_W-1:0]   r_upright,      n_upright;
    logic signed [TURN_SUM_W-1:0] r_turn,     n_turn;
    t_out_item                r_out,          n_out;
    logic                     r_out_valid;

    // Combinational temporaries
    logic signed [RMP_S_W-1:0]   spd_sum;
    logic signed [RMP_T_W-1:0]   turn_sum;
    logic signed [MIX_W-1:0]     mix, mix_abs;
    logic signed [MUL_A_W-1:0]   mul_a, turn_kd;
    logic signed [MUL_B_W-1:0]   mul_b, setpoint, ang_err;
    logic signed [FE_W-1:0]      quot;
    logic signed [INT_SUM_W-1:0] int_sum;
    logic signed [ACC_W-1:0]     bias, biased;
    logic signed [VRAW_W-1:0]    vraw;
    logic signed [DRV_SUM_W-1:0] dsum_l, dsum_r, lim;
    logic                        turning;

    // Speed and turn target ramps
    always_comb begin
        spd_sum = (r_in.fwd_btn || r_in.back_btn) ? RMP_S_W'(r_speed_target) : '0;
        if (r_in.fwd_btn) begin
            spd_sum = r_in.obstacle_near ? spd_sum + RMP_S_W'(1) : spd_sum - RMP_S_W'(1);
        end
        if (r_in.back_btn) begin
            spd_sum = spd_sum + RMP_S_W'(1);
        end
        if (spd_sum > SPD_HI) begin
            spd_sum = SPD_HI;
        end else if (spd_sum < SPD_LO) begin
            spd_sum = SPD_LO;
        end
        n_speed_target = SPD_W'(spd_sum);

        turning  = r_in.left_btn || r_in.right_btn;
        turn_sum = turning ? RMP_T_W'(r_turn_target) : '0;
        if (r_in.left_btn) begin
            turn_sum = turn_sum + TSTEP;
        end
        if (r_in.right_btn) begin
            turn_sum = turn_sum - TSTEP;
        end
        if (turn_sum > TURN_HI) begin
            turn_sum = TURN_HI;
        end else if (turn_sum < TURN_LO) begin
            turn_sum = TURN_LO;
        end
        n_turn_target = TURN_W'(turn_sum);

        n_err = ERR_W'(r_in.enc_left) - ERR_W'(r_in.enc_right_raw)
              - ERR_W'(n_speed_target);
    end

    // Filter mix 3*err + 7*fe and its magnitude for the divide by ten
    always_comb begin
        mix = MIX_W'(r_err) + (MIX_W'(r_err) <<< 1)
            + (MIX_W'(r_fe) <<< 3) - MIX_W'(r_fe);
        mix_abs = mix[MIX_W-1] ? -mix : mix;
    end

    // Quotient back to signed, truncated toward zero
    always_comb begin
        quot = signed'(r_prod[RECIP_SHIFT +: FE_W]);
        n_fe = r_neg ? -quot : quot;
    end

    // Integral update with clamp and clear
    always_comb begin
        int_sum = INT_SUM_W'(r_si) + INT_SUM_W'(r_fe);
        if (int_sum > INT_HI) begin
            int_sum = INT_HI;
        end else if (int_sum < INT_LO) begin
            int_sum = INT_LO;
        end
        n_si = r_in.clear_integral ? '0 : INT_W'(int_sum);
    end

    // Shared multiplier operands
    always_comb begin
        turn_kd  = turning ? '0 : i_cfg.steer_kd;
        setpoint = (MUL_B_W'(r_vel) <<< 8) + MUL_B_W'(i_cfg.balance_offset);
        ang_err  = MUL_B_W'(r_in.roll_angle) - setpoint;
        unique case (i_cmd.mul_sel)
            MS_RECIP: begin
                mul_a = MUL_A_W'(RECIP10);
                mul_b = MUL_B_W'(mix_abs);
            end
            MS_SKP: begin
                mul_a = i_cfg.speed_kp;
                mul_b = MUL_B_W'(r_fe);
            end
            MS_SKI: begin
                mul_a = i_cfg.speed_ki;
                mul_b = MUL_B_W'(r_si);
            end
            MS_UKP: begin
                mul_a = i_cfg.upright_kp;
                mul_b = ang_err;
            end
            MS_UKD: begin
                mul_a = i_cfg.upright_kd;
                mul_b = MUL_B_W'(r_in.gyro_x);
            end
            MS_TKP: begin
                mul_a = i_cfg.steer_kp;
                mul_b = MUL_B_W'(r_turn_target);
            end
            MS_TKD: begin
                mul_a = turn_kd;
                mul_b = MUL_B_W'(r_in.gyro_z);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        n_prod = mul_a * mul_b;
    end

    // Accumulator
    always_comb begin
        unique case (i_cmd.acc_op)
            ACC_HOLD:    n_acc = r_acc;
            ACC_LOAD:    n_acc = ACC_W'(r_prod);
            ACC_ADD:     n_acc = r_acc + ACC_W'(r_prod);
            ACC_ADD_SH8: n_acc = r_acc + (ACC_W'(r_prod) <<< 8);
            default:     n_acc = r_acc;
        endcase
    end

    // Shift right with truncation toward zero
    always_comb begin
        bias   = r_acc[ACC_W-1] ? (i_cmd.trunc_hi ? BIAS_HI : BIAS_LO) : '0;
        biased = r_acc + bias;
        vraw   = signed'(biased[ACC_W-1:TRUNC_LO]);
        if (vraw > VEL_HI) begin
            n_vel = VEL_W'(VEL_HI);
        end else if (vraw < VEL_LO) begin
            n_vel = VEL_W'(VEL_LO);
        end else begin
            n_vel = VEL_W'(vraw);
        end
        n_upright = signed'(biased[ACC_W-1:TRUNC_HI]);
        n_turn    = TURN_SUM_W'(vraw);
    end

    // Motor mix and saturation
    always_comb begin
        lim    = DRV_SUM_W'(signed'({1'b0, i_cfg.drive_limit}));
        dsum_l = DRV_SUM_W'(r_upright) - DRV_SUM_W'(r_turn);
        dsum_r = DRV_SUM_W'(r_upright) + DRV_SUM_W'(r_turn);
        if (dsum_l > lim) begin
            dsum_l = lim;
        end else if (dsum_l < -lim) begin
            dsum_l = -lim;
        end
        if (dsum_r > lim) begin
            dsum_r = lim;
        end else if (dsum_r < -lim) begin
            dsum_r = -lim;
        end
        n_out.drive_left  = DRV_W'(dsum_l);
        n_out.drive_right = DRV_W'(dsum_r);
    end

    // Loop state, reset to zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_target <= '0;
            r_turn_target  <= '0;
            r_fe           <= '0;
            r_si           <= '0;
        end else begin
            if (i_cmd.ramp) begin
                r_speed_target <= n_speed_target;
                r_turn_target  <= n_turn_target;
            end
            if (i_cmd.div_fin) begin
                r_fe <= n_fe;
            end
            if (i_cmd.int_upd) begin
                r_si <= n_si;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_in <= i_in_data;
        end
        if (i_cmd.ramp) begin
            r_err <= n_err;
        end
        if (i_cmd.div_start) begin
            r_neg <= mix[MIX_W-1];
        end
        if (i_cmd.vel_upd) begin
            r_vel <= n_vel;
        end
        if (i_cmd.up_upd) begin
            r_upright <= n_upright;
        end
        if (i_cmd.turn_upd) begin
            r_turn <= n_turn;
        end
        if (i_cmd.out_load) begin
            r_out <= n_out;
        end
        r_prod <= n_prod;
        r_acc  <= n_acc;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out;

endmodule

FILE: hdl/balance_car_cascaded_pid_core.sv
// Cascaded PID controller for a two-wheel balancing car.
// Input channel (i_in_valid / o_in_ready / i_in_data): one control tick per
// item with encoder counts, roll angle, gyro rates and command flags.
// Output channel (o_out_valid / i_out_ready / o_out_data): one item per tick
// with the left and right motor drives, saturated at +-drive_limit.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx;
// write only while no tick is in flight.
// Timing: a tick is sequenced over one shared 32x25 multiplier and one
// accumulator through the states RAMP to TURN. The result is loaded into the
// output register in OUT, and the next item is accepted only once the
// sequencer is back in IDLE, so a new item never overlaps the last one.
// Stall: the output register holds a finished item until it is taken; the
// next item may be accepted and worked on meanwhile, but its result waits
// in the last step until the output register frees.
// Reset (synchronous, active low): gains return to their defaults and the
// speed/turn targets, filtered error and speed integral clear to zero.
module balance_car_cascaded_pid_core
    import bccp_pkg::*;
#(
    parameter int SPEED_TARGET_MAX = SPEED_TARGET_MAX_DEF,
    parameter int TURN_TARGET_MAX  = TURN_TARGET_MAX_DEF,
    parameter int INTEGRAL_LIMIT   = INTEGRAL_LIMIT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    t_dp_cmd    cmd;
    t_dp_status status;

    // Configuration register file
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                REG_UPRIGHT_KP:     n_cfg.upright_kp     = i_cfg_data;
                REG_UPRIGHT_KD:     n_cfg.upright_kd     = i_cfg_data;
                REG_SPEED_KP:       n_cfg.speed_kp       = i_cfg_data;
                REG_SPEED_KI:       n_cfg.speed_ki       = i_cfg_data;
                REG_STEER_KP:       n_cfg.steer_kp       = i_cfg_data;
                REG_STEER_KD:       n_cfg.steer_kd       = i_cfg_data;
                REG_BALANCE_OFFSET: n_cfg.balance_offset = i_cfg_data[15:0];
                REG_DRIVE_LIMIT:    n_cfg.drive_limit    = i_cfg_data[LIM_W-1:0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Sequencer
    bccp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // Datapath
    bccp_dp #(
        .SPEED_TARGET_MAX (SPEED_TARGET_MAX),
        .TURN_TARGET_MAX  (TURN_TARGET_MAX),
        .INTEGRAL_LIMIT   (INTEGRAL_LIMIT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .i_out_ready (i_out_ready),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // A tick in flight blocks the next item
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted again right after an accept");

    // The result is only loaded when the output register can take it
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> status.out_free)
        else $error("result loaded over a pending item");

    // Ramp step follows every accept
    a_ramp_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.in_load |=> cmd.ramp)
        else $error("ramp step missing after accept");

    // Never accept and deliver in the same cycle
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.in_load && cmd.out_load))
        else $error("accept and result load overlap");

endmodule

FILE: tb/balance_car_cascaded_pid_core_tb.sv
module balance_car_cascaded_pid_core_tb;
    import bccp_pkg::*;

    localparam int RANDOM_TICKS  = 1250;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 30;
    localparam int DIR_ROWS      = 23;
    localparam int CALM_TICKS    = 250;

    // Button bits in item order: fwd, back, left, right, obstacle, clear
    localparam logic [5:0] B_FWD   = 6'b100000;
    localparam logic [5:0] B_BACK  = 6'b010000;
    localparam logic [5:0] B_LEFT  = 6'b001000;
    localparam logic [5:0] B_RIGHT = 6'b000100;
    localparam logic [5:0] B_OBST  = 6'b000010;
    localparam logic [5:0] B_CLR   = 6'b000001;

    // One directed row: a register write, or an item sent reps times
    typedef struct packed {
        logic              is_reg;
        t_cfg_idx          idx;
        logic [CFG_W-1:0]  val;
        logic [5:0]        reps;
        logic              typed;
        t_out_item         want;
        t_in_item          tick;
    } dir_row_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    t_in_item             in_data   = '0;
    logic                 out_ready = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 in_ready;
    logic                 out_valid;
    t_out_item            out_data;

    // Predictor copy of the registers and the loop state
    t_cfg               gains     = CFG_RESET;
    logic signed [4:0]  speed_tgt = '0;
    logic signed [7:0]  turn_tgt  = '0;
    logic signed [17:0] filt_err  = '0;
    logic signed [15:0] speed_int = '0;

    t_out_item drive_q [$];
    dir_row_t  dir_tab [DIR_ROWS];
    bit        calm      = 1'b0;
    logic [4:0] hold_btns = '0;
    int        hold_left = 0;
    int        n_bad     = 0;
    int        quiet     = 0;

    balance_car_cascaded_pid_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic longint sat(longint v, longint lo, longint hi);
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    // One control tick: ramps, velocity PI, upright PD, turn PD, saturation
    function automatic t_out_item control_tick(t_in_item t);
        longint spd, trn, kd, err, fe, integ, vel, setp, upr, turn, lim;
        t_out_item d;
        spd = (t.fwd_btn || t.back_btn) ? longint'(speed_tgt) : 0;
        if (t.fwd_btn) spd += t.obstacle_near ? 1 : -1;
        if (t.back_btn) spd += 1;
        spd = sat(spd, -SPEED_TARGET_MAX_DEF, SPEED_TARGET_MAX_DEF);
        trn = (t.left_btn || t.right_btn) ? longint'(turn_tgt) : 0;
        if (t.left_btn) trn += TURN_STEP;
        if (t.right_btn) trn -= TURN_STEP;
        trn = sat(trn, -TURN_TARGET_MAX_DEF, TURN_TARGET_MAX_DEF);
        // gyro damping of the turn loop only with no turn button held
        kd = (t.left_btn || t.right_btn) ? 0 : longint'($signed(gains.steer_kd));

        err = longint'($signed(t.enc_left)) - longint'($signed(t.enc_right_raw)) - spd;
        fe = (3 * err + 7 * longint'(filt_err)) / 10;
        integ = sat(longint'(speed_int) + fe, -INTEGRAL_LIMIT_DEF, INTEGRAL_LIMIT_DEF);
        if (t.clear_integral) integ = 0;
        vel = (longint'($signed(gains.speed_kp)) * fe
               + longint'($signed(gains.speed_ki)) * integ) / 65536;
        vel = sat(vel, -32768, 32767);

        setp = vel * 256 + longint'($signed(gains.balance_offset));
        upr = (longint'($signed(gains.upright_kp)) * (longint'($signed(t.roll_angle)) - setp)
               + longint'($signed(gains.upright_kd)) * longint'($signed(t.gyro_x)) * 256)
              / 64'sd16777216;
        turn = (longint'($signed(gains.steer_kp)) * trn
                + kd * longint'($signed(t.gyro_z))) / 65536;
        lim = longint'(gains.drive_limit);

        speed_tgt = spd[4:0];
        turn_tgt  = trn[7:0];
        filt_err  = fe[17:0];
        speed_int = integ[15:0];
        d.drive_left  = 16'(sat(upr - turn, -lim, lim));
        d.drive_right = 16'(sat(upr + turn, -lim, lim));
        return d;
    endfunction

    function automatic dir_row_t tick_row(int l, int r, int roll, int gx, int gz,
                                          logic [5:0] btn, int reps);
        dir_row_t d;
        d = '0;
        d.tick = {16'(l), 16'(r), 16'(roll), 16'(gx), 16'(gz), btn};
        d.reps = 6'(reps);
        return d;
    endfunction

    function automatic dir_row_t fixed_row(int l, int r, int roll, int gx, int gz,
                                           logic [5:0] btn, int wl, int wr);
        dir_row_t d;
        d = tick_row(l, r, roll, gx, gz, btn, 1);
        d.typed = 1'b1;
        d.want = {16'(wl), 16'(wr)};
        return d;
    endfunction

    function automatic dir_row_t reg_row(t_cfg_idx idx, logic [CFG_W-1:0] val);
        dir_row_t d;
        d = '0;
        d.is_reg = 1'b1;
        d.idx = idx;
        d.val = val;
        return d;
    endfunction

    function automatic logic [31:0] extreme32();
        return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endfunction

    function automatic bit take_break();
        return !calm && ($urandom_range(0, 99) < 24);
    endfunction

    // Random item: buttons held over runs so the ramps reach their bounds
    function automatic t_in_item make_tick();
        t_in_item t;
        logic [4:0] b;
        if (hold_left == 0) begin
            hold_btns = 5'($urandom);
            hold_left = $urandom_range(1, 25);
        end
        hold_left--;
        b = hold_btns;
        // stray pattern now and then breaks up a held run
        if ($urandom_range(0, 9) == 0) b = 5'($urandom);
        if ($urandom_range(0, 3) == 0) begin
            t.enc_left      = 16'($urandom);
            t.enc_right_raw = 16'($urandom);
            t.roll_angle    = 16'($urandom);
            t.gyro_x        = 16'($urandom);
            t.gyro_z        = 16'($urandom);
        end else begin
            t.enc_left      = 16'($urandom_range(0, 600) - 300);
            t.enc_right_raw = 16'($urandom_range(0, 600) - 300);
            t.roll_angle    = 16'($urandom_range(0, 8000) - 4000);
            t.gyro_x        = 16'($urandom_range(0, 6000) - 3000);
            t.gyro_z        = 16'($urandom_range(0, 6000) - 3000);
        end
        {t.fwd_btn, t.back_btn, t.left_btn, t.right_btn, t.obstacle_near} = b;
        t.clear_integral = ($urandom_range(0, 19) == 0);
        return t;
    endfunction

    // Send one item, predict its drives at acceptance
    task automatic push_tick(input t_in_item t, input bit typed, input t_out_item typed_drv);
        t_out_item d;
        while (take_break()) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= t;
        do @(posedge clk); while (!in_ready);
        d = control_tick(t);
        drive_q.push_back(typed ? typed_drv : d);
    endtask

    task automatic reg_write(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            REG_UPRIGHT_KP:     gains.upright_kp     = val;
            REG_UPRIGHT_KD:     gains.upright_kd     = val;
            REG_SPEED_KP:       gains.speed_kp       = val;
            REG_SPEED_KI:       gains.speed_ki       = val;
            REG_STEER_KP:       gains.steer_kp       = val;
            REG_STEER_KD:       gains.steer_kd       = val;
            REG_BALANCE_OFFSET: gains.balance_offset = val[15:0];
            REG_DRIVE_LIMIT:    gains.drive_limit    = val[LIM_W-1:0];
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Stop sending and wait until every predicted item has come back
    task automatic settle();
        in_valid <= 1'b0;
        while (drive_q.size() != 0) @(posedge clk);
    endtask

    // Stimulus: directed table, then random phases over several settings
    initial begin
        int sent;
        int n;
        int phase;
        t_cfg c;
        dir_tab = '{
            fixed_row(0, 0, 0, 0, 0, 6'b0, 0, 0),
            tick_row(32767, -32768, 32767, 32767, -32768, 6'b0, 1),
            tick_row(-32768, 32767, -32768, -32768, 32767, 6'b0, 1),
            tick_row(5, -3, 200, -100, 50, B_FWD, 1),
            tick_row(5, -3, 200, -100, 50, B_FWD | B_OBST, 1),
            tick_row(-2, 4, -120, 60, -90, B_FWD | B_BACK, 1),
            tick_row(10, 2, -300, 40, -40, B_FWD | B_BACK | B_OBST, 6),
            tick_row(-7, 7, -50, 20, 300, B_LEFT, 4),
            tick_row(3, 3, 0, 0, -2000, B_LEFT | B_RIGHT, 1),
            tick_row(32767, -32768, 0, 0, 0, 6'b0, 2),
            tick_row(0, 0, 0, 0, 0, B_CLR, 1),
            tick_row(-32768, 32767, 0, 0, 0, B_RIGHT, 4),
            reg_row(REG_SPEED_KP, 32'h7FFF_FFFF),
            reg_row(REG_SPEED_KI, 32'h7FFF_FFFF),
            tick_row(-32768, 32767, -32768, 0, 0, 6'b0, 1),
            reg_row(REG_SPEED_KP, 32'h8000_0000),
            reg_row(REG_SPEED_KI, 32'h8000_0000),
            tick_row(-32768, 32767, 32767, 0, 0, 6'b0, 1),
            reg_row(REG_DRIVE_LIMIT, 32'd0),
            fixed_row(32767, -32768, 32767, -32768, 32767, B_LEFT, 0, 0),
            reg_row(REG_DRIVE_LIMIT, 32'h0000_7FFF),
            tick_row(-32768, 32767, -32768, 32767, -32768, B_RIGHT, 1),
            tick_row(12, -12, 0, 0, 0, B_FWD | B_LEFT | B_CLR, 1)
        };
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            if (dir_tab[r].is_reg) begin
                settle();
                reg_write(dir_tab[r].idx, dir_tab[r].val);
            end else begin
                repeat (dir_tab[r].reps) push_tick(dir_tab[r].tick, dir_tab[r].typed,
                                                   dir_tab[r].want);
            end
        end

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_TICKS) begin
            settle();
            c = CFG_RESET;
            case (phase % 5)
                1, 3: begin
                    // gains scattered around the tuned defaults
                    c.upright_kp     = -int'($urandom_range(0, 24000000));
                    c.upright_kd     = -int'($urandom_range(0, 120000));
                    c.speed_kp       = -int'($urandom_range(0, 105000));
                    c.speed_ki       = -int'($urandom_range(0, 600));
                    c.steer_kp       = $urandom_range(0, 1310720);
                    c.steer_kd       = $urandom_range(0, 80000);
                    c.balance_offset = 16'(int'($urandom_range(0, 1024)) - 512);
                    c.drive_limit    = 15'($urandom_range(500, 12000));
                end
                2: begin
                    c.upright_kp     = $urandom;
                    c.upright_kd     = $urandom;
                    c.speed_kp       = $urandom;
                    c.speed_ki       = $urandom;
                    c.steer_kp       = $urandom;
                    c.steer_kd       = $urandom;
                    c.balance_offset = 16'($urandom);
                    c.drive_limit    = 15'($urandom);
                end
                4: begin
                    c.upright_kp     = extreme32();
                    c.upright_kd     = extreme32();
                    c.speed_kp       = extreme32();
                    c.speed_ki       = extreme32();
                    c.steer_kp       = extreme32();
                    c.steer_kd       = extreme32();
                    c.balance_offset = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                    c.drive_limit    = $urandom_range(0, 1) ? 15'h7FFF : 15'h0000;
                end
                default: ;
            endcase
            reg_write(REG_UPRIGHT_KP, c.upright_kp);
            reg_write(REG_UPRIGHT_KD, c.upright_kd);
            reg_write(REG_SPEED_KP, c.speed_kp);
            reg_write(REG_SPEED_KI, c.speed_ki);
            reg_write(REG_STEER_KP, c.steer_kp);
            reg_write(REG_STEER_KD, c.steer_kd);
            reg_write(REG_BALANCE_OFFSET, 32'(c.balance_offset));
            reg_write(REG_DRIVE_LIMIT, 32'(c.drive_limit));

            // one long phase runs with no gaps on either side
            calm = (phase == 1);
            n = calm ? CALM_TICKS : $urandom_range(60, 140);
            if (n > RANDOM_TICKS - sent) n = RANDOM_TICKS - sent;
            repeat (n) push_tick(make_tick(), 1'b0, '0);
            sent += n;
            phase++;
        end

        settle();
        calm = 1'b0;
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (n_bad == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Output side stalls at random
    always @(posedge clk) begin
        out_ready <= calm || ($urandom_range(0, 99) >= 24);
    end

    // Drive check against the oldest prediction, plus the stall watchdog
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (drive_q.size() == 0) begin
                if (n_bad < 10)
                    $display("unexpected drive item: L=%0d R=%0d",
                             out_data.drive_left, out_data.drive_right);
                n_bad++;
            end else begin
                want = drive_q.pop_front();
                if (want.drive_left !== out_data.drive_left ||
                    want.drive_right !== out_data.drive_right) begin
                    if (n_bad < 10)
                        $display("drive mismatch: expected L=%0d R=%0d, got L=%0d R=%0d",
                                 want.drive_left, want.drive_right,
                                 out_data.drive_left, out_data.drive_right);
                    n_bad++;
                end
            end
        end

        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

endmodule

FILE: balance_car_cascaded_pid_core.f
hdl/bccp_pkg.sv
hdl/bccp_ctrl.sv
hdl/bccp_dp.sv
hdl/balance_car_cascaded_pid_core.sv
tb/balance_car_cascaded_pid_core_tb.sv
